>>> src/tgapd_pkg.sv
package tgapd_pkg;

    // Dimension registers are 13 bits wide; the pixel count may run past the
    // image total, so it gets one extra bit.
    localparam int DIM_W     = 13;
    localparam int TOT_W     = 2 * DIM_W;
    localparam int PC_W      = TOT_W + 1;
    localparam int PC_CNT_W  = $clog2(PC_W);
    localparam int LEN_W     = 8;
    localparam int IDX_W     = 3;

    typedef logic [DIM_W:0] dimc_t;

    typedef enum logic [IDX_W-1:0] {
        REG_IMAGE_WIDTH     = 3'd0,
        REG_IMAGE_HEIGHT    = 3'd1,
        REG_RLE_MODE        = 3'd2,
        REG_BYTES_PER_PIXEL = 3'd3,
        REG_PALETTED        = 3'd4,
        REG_FLIP_ROWS       = 3'd5
    } reg_idx_t;

    localparam logic REQ_PALETTE = 1'b0;
    localparam logic REQ_DATA    = 1'b1;

    localparam logic [2:0] BPP_1 = 3'd1;
    localparam logic [2:0] BPP_2 = 3'd2;
    localparam logic [2:0] BPP_3 = 3'd3;
    localparam logic [2:0] BPP_4 = 3'd4;

    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
    localparam logic [7:0] MASK_R5      = 8'h7c;
    localparam logic [7:0] MASK_G3_LO   = 8'he0;
    localparam logic [7:0] MASK_B5      = 8'h1f;
    localparam logic [7:0] MASK_ALPHA   = 8'h80;
    localparam logic [7:0] MASK_G2_HI   = 8'h03;
    localparam logic [7:0] MASK_COUNT   = 8'h7f;

    // Effective configuration, already clamped into range
    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic             rle;
        logic [2:0]       bpp;
        logic             paletted;
        logic             flip;
    } cfg_t;

    typedef struct packed {
        logic [TOT_W-1:0] base;   // (height - 1) * width
        logic [TOT_W-1:0] total;  // height * width
    } geom_t;

    typedef struct packed {
        logic             valid;
        logic [LEN_W-1:0] len;
    } adv_t;

    typedef struct packed {
        logic [PC_W-1:0]  pixel_count;
        logic [DIM_W-1:0] column;
        logic             busy;
    } rast_t;

    typedef struct packed {
        logic [23:0]      start_index;
        logic [23:0]      start_address;
        logic [LEN_W-1:0] run_length;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [7:0]       alpha;
        logic             image_done;
    } out_t;

    typedef struct packed {
        out_t run;
        logic use_palette;
        logic pal_zero;
        logic pal_oob;
    } rec_t;

endpackage

>>> src/tgapd_palette_ram.sv
module tgapd_palette_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [23:0]   wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [23:0]   rdata
);

    logic [23:0] mem [DEPTH];
    logic [23:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/tgapd_cfg.sv
module tgapd_cfg import tgapd_pkg::*; #(
    parameter int MAX_DIM = 4096
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0] cfg_wdata,
    output cfg_t             cfg,
    output geom_t            geom,
    output logic             dim_wr,
    output logic             busy
);

    localparam dimc_t DIM_LIMIT = (MAX_DIM >= (1 << DIM_W)) ? dimc_t'((1 << DIM_W) - 1)
                                                            : dimc_t'(MAX_DIM);

    logic [DIM_W-1:0] width_reg, height_reg;
    logic             rle_reg, paletted_reg, flip_reg;
    logic [2:0]       bpp_reg;
    logic [TOT_W-1:0] base_reg, total_reg;
    logic [1:0]       upd_reg;
    logic [DIM_W-1:0] w_eff, h_eff, hm1;
    logic [2:0]       bpp_eff;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if ({1'b0, v} > DIM_LIMIT) begin
            r = DIM_LIMIT[DIM_W-1:0];
        end
        return r;
    endfunction

    always_comb begin
        w_eff = clamp_dim(width_reg);
        h_eff = clamp_dim(height_reg);
        hm1   = h_eff - DIM_W'(1);
        if (bpp_reg == 3'd0) begin
            bpp_eff = BPP_1;
        end else if (bpp_reg > BPP_4) begin
            bpp_eff = BPP_4;
        end else begin
            bpp_eff = bpp_reg;
        end
    end

    assign dim_wr = cfg_wr_en && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= DIM_W'(1);
            height_reg   <= DIM_W'(1);
            rle_reg      <= 1'b0;
            bpp_reg      <= BPP_4;
            paletted_reg <= 1'b0;
            flip_reg     <= 1'b0;
            base_reg     <= '0;
            total_reg    <= TOT_W'(1);
            upd_reg      <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_IMAGE_WIDTH:     width_reg    <= cfg_wdata;
                    REG_IMAGE_HEIGHT:    height_reg   <= cfg_wdata;
                    REG_RLE_MODE:        rle_reg      <= cfg_wdata[0];
                    REG_BYTES_PER_PIXEL: bpp_reg      <= cfg_wdata[2:0];
                    REG_PALETTED:        paletted_reg <= cfg_wdata[0];
                    REG_FLIP_ROWS:       flip_reg     <= cfg_wdata[0];
                    default: ;
                endcase
            end
            // two steps: multiply, then add one more row to get the total
            upd_reg <= {upd_reg[0], dim_wr};
            if (upd_reg[0]) begin
                base_reg <= hm1 * w_eff;
            end
            if (upd_reg[1]) begin
                total_reg <= base_reg + TOT_W'(w_eff);
            end
        end
    end

    assign busy = |upd_reg;

    always_comb begin
        cfg.width    = w_eff;
        cfg.height   = h_eff;
        cfg.rle      = rle_reg;
        cfg.bpp      = bpp_eff;
        cfg.paletted = paletted_reg;
        cfg.flip     = flip_reg;
        geom.base    = base_reg;
        geom.total   = total_reg;
    end

endmodule

>>> src/tgapd_raster.sv
module tgapd_raster import tgapd_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [DIM_W-1:0] width,
    input  logic             start,
    input  adv_t             adv,
    output rast_t            rast
);

    localparam logic [PC_CNT_W-1:0] CNT_TOP = PC_CNT_W'(PC_W - 1);

    logic [PC_W-1:0]     pixel_count_reg, pixel_count_next;
    logic [DIM_W-1:0]    column_reg, column_next;
    logic [DIM_W:0]      sum_reg, sum_next;
    logic                fix_pending_reg, fix_pending_next;
    logic                div_active_reg, div_active_next;
    logic [PC_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [DIM_W-1:0]    rem_reg, rem_next;

    logic [DIM_W:0]      trial, col_inc;
    logic [DIM_W-1:0]    rem_step, fix_col;
    logic [20:0]         fr, fd;

    // bit-serial remainder of the pixel count by the width
    always_comb begin
        trial    = {rem_reg, pixel_count_reg[div_cnt_reg]};
        rem_step = (trial >= {1'b0, width}) ? DIM_W'(trial - {1'b0, width}) : trial[DIM_W-1:0];
    end

    // wrap column + run length back under the width; quotient fits in 8 bits
    always_comb begin
        fr = 21'(sum_reg);
        fd = '0;
        for (int i = 7; i >= 0; i--) begin
            fd = 21'(width) << i;
            if (fr >= fd) begin
                fr = fr - fd;
            end
        end
        fix_col = fr[DIM_W-1:0];
    end

    always_comb begin
        pixel_count_next = pixel_count_reg;
        column_next      = column_reg;
        sum_next         = sum_reg;
        fix_pending_next = 1'b0;
        div_active_next  = div_active_reg;
        div_cnt_next     = div_cnt_reg;
        rem_next         = rem_reg;
        col_inc          = {1'b0, column_reg} + (DIM_W+1)'(1);

        if (adv.valid) begin
            pixel_count_next = pixel_count_reg + PC_W'(adv.len);
            if (adv.len == LEN_W'(1)) begin
                column_next = (col_inc == {1'b0, width}) ? '0 : col_inc[DIM_W-1:0];
            end else begin
                // long runs are wrapped in the following cycle
                fix_pending_next = 1'b1;
                sum_next         = {1'b0, column_reg} + (DIM_W+1)'(adv.len);
            end
        end

        if (fix_pending_reg) begin
            column_next = fix_col;
        end

        if (start) begin
            div_active_next = 1'b1;
            div_cnt_next    = CNT_TOP;
            rem_next        = '0;
        end else if (div_active_reg) begin
            rem_next = rem_step;
            if (div_cnt_reg == '0) begin
                div_active_next = 1'b0;
                column_next     = rem_step;
            end else begin
                div_cnt_next = div_cnt_reg - PC_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_count_reg <= '0;
            column_reg      <= '0;
            sum_reg         <= '0;
            fix_pending_reg <= 1'b0;
            div_active_reg  <= 1'b0;
            div_cnt_reg     <= '0;
            rem_reg         <= '0;
        end else begin
            pixel_count_reg <= pixel_count_next;
            column_reg      <= column_next;
            sum_reg         <= sum_next;
            fix_pending_reg <= fix_pending_next;
            div_active_reg  <= div_active_next;
            div_cnt_reg     <= div_cnt_next;
            rem_reg         <= rem_next;
        end
    end

    always_comb begin
        rast.pixel_count = pixel_count_reg;
        rast.column      = column_reg;
        rast.busy        = div_active_reg;
    end

    // a long run is always followed by a header byte, so the wrap cycle sees no run
    assert property (@(posedge aclk) disable iff (!aresetn)
        fix_pending_reg |-> !adv.valid)
        else $error("run advanced while column wrap pending");

    assert property (@(posedge aclk) disable iff (!aresetn)
        div_active_reg |-> !adv.valid)
        else $error("run advanced during column rebuild");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (!div_active_reg && !fix_pending_reg && !$past(start)) |-> (column_reg < width))
        else $error("column out of range");

endmodule

>>> src/tga_pixel_stream_decoder.sv
// A run loads stage b with its last pixel byte, then moves to stage c, whose valid is m_valid.
// Throughput: one input transaction per cycle while s_ready is high; one per pixel byte or header.
// s_ready also drops while both run stages are full and m_ready is low.
// The palette RAM is synchronous and registered; each nonzero in-range paletted pixel reads it once.
// A write to image_width or image_height holds s_ready low while column and geometry are rebuilt.
// Active-low synchronous reset clears counters, packet state, valid flags; not run data or palette.
module tga_pixel_stream_decoder import tgapd_pkg::*; #(
    parameter int MAX_DIM       = 4096,
    parameter int PALETTE_DEPTH = 256
) (
    input  logic             aclk,
    input  logic             aresetn,

    input  logic             cfg_wr_en,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0] cfg_wdata,

    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_req_type,
    input  logic [7:0]       s_palette_index,
    input  logic [23:0]      s_palette_colour,
    input  logic [7:0]       s_data_byte,

    output logic             m_valid,
    input  logic             m_ready,
    output logic [23:0]      m_start_index,
    output logic [23:0]      m_start_address,
    output logic [7:0]       m_run_length,
    output logic [7:0]       m_red,
    output logic [7:0]       m_green,
    output logic [7:0]       m_blue,
    output logic [7:0]       m_alpha,
    output logic             m_image_done
);

    localparam int         PAL_AW    = $clog2(PALETTE_DEPTH);
    localparam logic [8:0] PAL_LIMIT = 9'(PALETTE_DEPTH);

    cfg_t  cfg;
    geom_t geom;
    rast_t rast;
    adv_t  adv;
    logic  dim_wr, geo_busy;

    logic [LEN_W-1:0] pkt_rem_reg, pkt_rem_next;
    logic             pkt_rep_reg, pkt_rep_next;
    logic [1:0]       phase_reg, phase_next;
    logic [23:0]      buf_reg, buf_next;

    logic b_valid_reg, b_valid_next;
    rec_t b_rec_reg, b_rec_next;
    logic c_valid_reg, c_valid_next;
    out_t c_out_reg, c_out_next;

    logic              accept, done_now, data_live, header, complete, b_load, b_move;
    logic [31:0]       pix_bytes;
    logic [7:0]        p0, p1, p2, p3;
    logic [7:0]        dr, dg, db, da;
    logic [LEN_W-1:0]  len_raw, len_clamp;
    logic [TOT_W-1:0]  remain;
    logic [PC_W-1:0]   pc_after;
    logic              pal_we, pal_re, p0_oob;
    logic [23:0]       pal_rdata;

    tgapd_cfg #(
        .MAX_DIM (MAX_DIM)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg),
        .geom      (geom),
        .dim_wr    (dim_wr),
        .busy      (geo_busy)
    );

    tgapd_raster u_raster (
        .aclk    (aclk),
        .aresetn (aresetn),
        .width   (cfg.width),
        .start   (dim_wr),
        .adv     (adv),
        .rast    (rast)
    );

    tgapd_palette_ram #(
        .DEPTH (PALETTE_DEPTH),
        .AW    (PAL_AW)
    ) u_palette (
        .aclk  (aclk),
        .we    (pal_we),
        .waddr (s_palette_index[PAL_AW-1:0]),
        .wdata (s_palette_colour),
        .re    (pal_re),
        .raddr (p0[PAL_AW-1:0]),
        .rdata (pal_rdata)
    );

    assign b_move  = b_valid_reg && (!c_valid_reg || m_ready);
    assign s_ready = !(rast.busy || geo_busy) && (!b_valid_reg || !c_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    // byte assembly, packet parsing, pixel decoding, palette access and run placement
    always_comb begin
        done_now  = rast.pixel_count >= {1'b0, geom.total};
        data_live = accept && (s_req_type == REQ_DATA) && !done_now;
        header    = cfg.rle && (pkt_rem_reg == '0);
        complete  = !header && (({1'b0, phase_reg} + 3'd1) >= cfg.bpp);
        b_load    = data_live && complete;

        pix_bytes = {8'd0, buf_reg} | (32'(s_data_byte) << {phase_reg, 3'b000});
        p0 = pix_bytes[7:0];
        p1 = pix_bytes[15:8];
        p2 = pix_bytes[23:16];
        p3 = pix_bytes[31:24];

        pkt_rem_next = pkt_rem_reg;
        pkt_rep_next = pkt_rep_reg;
        phase_next   = phase_reg;
        buf_next     = buf_reg;
        if (data_live) begin
            if (header) begin
                pkt_rem_next = (s_data_byte & MASK_COUNT) + LEN_W'(1);
                pkt_rep_next = s_data_byte[7];
                phase_next   = '0;
                buf_next     = '0;
            end else if (!complete) begin
                phase_next = phase_reg + 2'd1;
                buf_next   = pix_bytes[23:0];
            end else begin
                phase_next = '0;
                buf_next   = '0;
                if (cfg.rle) begin
                    pkt_rem_next = pkt_rep_reg ? '0 : pkt_rem_reg - LEN_W'(1);
                end
            end
        end

        len_raw   = (cfg.rle && pkt_rep_reg) ? pkt_rem_reg : LEN_W'(1);
        remain    = geom.total - rast.pixel_count[TOT_W-1:0];
        len_clamp = (TOT_W'(len_raw) > remain) ? remain[LEN_W-1:0] : len_raw;
        pc_after  = rast.pixel_count + PC_W'(len_clamp);

        dr = p0;
        dg = p0;
        db = p0;
        da = ALPHA_OPAQUE;
        if (cfg.bpp == BPP_4) begin
            dr = p2; dg = p1; db = p0; da = p3;
        end else if (cfg.bpp == BPP_3) begin
            dr = p2; dg = p1; db = p0;
        end else if (cfg.bpp == BPP_2) begin
            dr = (p1 & MASK_R5) << 1;
            dg = ((p1 & MASK_G2_HI) << 6) | ((p0 & MASK_G3_LO) >> 2);
            db = (p0 & MASK_B5) << 3;
            da = p1 & MASK_ALPHA;
        end

        p0_oob = !({1'b0, p0} < PAL_LIMIT);

        b_rec_next.run.start_index   = rast.pixel_count[23:0];
        b_rec_next.run.start_address = cfg.flip
            ? geom.base[23:0] + 24'({rast.column, 1'b0}) - rast.pixel_count[23:0]
            : rast.pixel_count[23:0];
        b_rec_next.run.run_length    = len_clamp;
        b_rec_next.run.red           = dr;
        b_rec_next.run.green         = dg;
        b_rec_next.run.blue          = db;
        b_rec_next.run.alpha         = da;
        b_rec_next.run.image_done    = pc_after >= {1'b0, geom.total};
        b_rec_next.use_palette       = cfg.paletted;
        b_rec_next.pal_zero          = (p0 == 8'd0);
        b_rec_next.pal_oob           = p0_oob;

        pal_re = b_load && cfg.paletted && (p0 != 8'd0) && !p0_oob;
        pal_we = accept && (s_req_type == REQ_PALETTE) && ({1'b0, s_palette_index} < PAL_LIMIT);

        adv.valid = b_load;
        adv.len   = len_clamp;

        b_valid_next = b_load || (b_valid_reg && !b_move);
        c_valid_next = b_move || (c_valid_reg && !m_ready);
    end

    // palette lookup lands here, applied to the run held in stage b
    always_comb begin
        c_out_next = b_rec_reg.run;
        if (b_rec_reg.use_palette) begin
            if (b_rec_reg.pal_zero) begin
                c_out_next.red   = '0;
                c_out_next.green = '0;
                c_out_next.blue  = '0;
                c_out_next.alpha = '0;
            end else if (b_rec_reg.pal_oob) begin
                c_out_next.red   = '0;
                c_out_next.green = '0;
                c_out_next.blue  = '0;
                c_out_next.alpha = ALPHA_OPAQUE;
            end else begin
                c_out_next.red   = pal_rdata[23:16];
                c_out_next.green = pal_rdata[15:8];
                c_out_next.blue  = pal_rdata[7:0];
                c_out_next.alpha = ALPHA_OPAQUE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pkt_rem_reg <= '0;
            pkt_rep_reg <= 1'b0;
            phase_reg   <= '0;
            buf_reg     <= '0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            pkt_rem_reg <= pkt_rem_next;
            pkt_rep_reg <= pkt_rep_next;
            phase_reg   <= phase_next;
            buf_reg     <= buf_next;
            b_valid_reg <= b_valid_next;
            c_valid_reg <= c_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_load) begin
            b_rec_reg <= b_rec_next;
        end
        if (b_move) begin
            c_out_reg <= c_out_next;
        end
    end

    assign m_valid         = c_valid_reg;
    assign m_start_index   = c_out_reg.start_index;
    assign m_start_address = c_out_reg.start_address;
    assign m_run_length    = c_out_reg.run_length;
    assign m_red           = c_out_reg.red;
    assign m_green         = c_out_reg.green;
    assign m_blue          = c_out_reg.blue;
    assign m_alpha         = c_out_reg.alpha;
    assign m_image_done    = c_out_reg.image_done;

    assert property (@(posedge aclk) disable iff (!aresetn)
        b_load |-> (!b_valid_reg || b_move))
        else $error("run overwrote a held stage");

    assert property (@(posedge aclk) disable iff (!aresetn)
        b_load |-> (len_clamp != '0))
        else $error("zero-length run");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (b_valid_reg && !b_move) |=> $stable(b_rec_reg))
        else $error("held run changed while blocked");

endmodule

>>> tb/tga_pixel_stream_decoder_test.sv
module tga_pixel_stream_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;
    import tgapd_pkg::*;

    localparam int FRAME_MAX     = 4096;
    localparam int SETTLE_CYCLES = 6;
    localparam int TAIL_CYCLES   = 16;
    localparam int MAX_REPORTS   = 10;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             cfg_wr_en = 1'b0;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0] cfg_wdata = '0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic             s_req_type = REQ_DATA;
    logic [7:0]       s_palette_index = '0;
    logic [23:0]      s_palette_colour = '0;
    logic [7:0]       s_data_byte = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [23:0]      m_start_index;
    logic [23:0]      m_start_address;
    logic [7:0]       m_run_length;
    logic [7:0]       m_red;
    logic [7:0]       m_green;
    logic [7:0]       m_blue;
    logic [7:0]       m_alpha;
    logic             m_image_done;

    // Decoder state as seen from the stream
    logic [23:0]      pal_mem [256];
    int unsigned      pix_cnt = 0;
    logic [31:0]      pend_bytes = '0;
    int unsigned      byte_idx = 0;
    int unsigned      pkt_left = 0;
    logic             pkt_rep = 1'b0;
    logic [DIM_W-1:0] cfg_w = 1;
    logic [DIM_W-1:0] cfg_h = 1;
    logic             cfg_rle = 1'b0;
    logic [2:0]       cfg_bpp = BPP_4;
    logic             cfg_pal = 1'b0;
    logic             cfg_flip = 1'b0;

    out_t             runs_pending [$];
    int unsigned      fail_count = 0;
    int unsigned      items_sent = 0;
    bit               gaps_on = 1'b1;

    tga_pixel_stream_decoder DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_palette_index (s_palette_index),
        .s_palette_colour(s_palette_colour),
        .s_data_byte     (s_data_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_start_index   (m_start_index),
        .m_start_address (m_start_address),
        .m_run_length    (m_run_length),
        .m_red           (m_red),
        .m_green         (m_green),
        .m_blue          (m_blue),
        .m_alpha         (m_alpha),
        .m_image_done    (m_image_done)
    );

    always #6 aclk = ~aclk;

    function automatic int unsigned dim_used(input logic [DIM_W-1:0] v);
        if (v == 0) return 1;
        if (v > FRAME_MAX) return FRAME_MAX;
        return v;
    endfunction

    function automatic int unsigned frame_total();
        return dim_used(cfg_w) * dim_used(cfg_h);
    endfunction

    function automatic int unsigned pixel_bytes();
        if (cfg_bpp == 0) return 1;
        if (cfg_bpp > BPP_4) return 4;
        return cfg_bpp;
    endfunction

    function automatic logic [7:0] rand_byte();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return 8'h00;
        if (pick == 1) return 8'hff;
        return 8'($urandom);
    endfunction

    function automatic string run_text(input out_t run);
        return $sformatf("index=%0d addr=%0d len=%0d r=%02h g=%02h b=%02h a=%02h done=%0b",
                         run.start_index, run.start_address, run.run_length, run.red,
                         run.green, run.blue, run.alpha, run.image_done);
    endfunction

    // Advance the decoder by one data byte and queue the run it completes, if any
    function automatic void decode_data_byte(input logic [7:0] b);
        int unsigned w, h, total, bpp, len, k;
        logic [7:0]  p [4];
        logic [7:0]  r, g, bl, a;
        logic [23:0] c;
        out_t        run;
        w = dim_used(cfg_w);
        h = dim_used(cfg_h);
        total = w * h;
        if (pix_cnt >= total) return;
        if (cfg_rle && pkt_left == 0) begin
            pkt_left = b[6:0] + 1;
            pkt_rep = b[7];
            pend_bytes = '0;
            byte_idx = 0;
            return;
        end
        bpp = pixel_bytes();
        if (byte_idx + 1 < bpp) begin
            pend_bytes[8*byte_idx +: 8] = b;
            byte_idx++;
            return;
        end
        for (k = 0; k < 4; k++) begin
            p[k] = (k < byte_idx) ? pend_bytes[8*k +: 8] : 8'h00;
        end
        p[byte_idx & 3] = b;
        pend_bytes = '0;
        byte_idx = 0;

        if (cfg_pal) begin
            if (p[0] == 8'h00) begin
                {r, g, bl, a} = '0;
            end else begin
                c = pal_mem[p[0]];
                {r, g, bl} = c;
                a = ALPHA_OPAQUE;
            end
        end else begin
            case (bpp)
                BPP_4: begin
                    r = p[2]; g = p[1]; bl = p[0]; a = p[3];
                end
                BPP_3: begin
                    r = p[2]; g = p[1]; bl = p[0]; a = ALPHA_OPAQUE;
                end
                BPP_2: begin
                    r  = {p[1][6:2], 3'b000};
                    g  = {p[1][1:0], p[0][7:5], 3'b000};
                    bl = {p[0][4:0], 3'b000};
                    a  = {p[1][7], 7'b0};
                end
                default: begin
                    r = p[0]; g = p[0]; bl = p[0]; a = ALPHA_OPAQUE;
                end
            endcase
        end

        len = 1;
        if (cfg_rle) begin
            if (pkt_rep) begin
                len = pkt_left;
                pkt_left = 0;
            end else begin
                pkt_left--;
            end
        end
        if (len > total - pix_cnt) len = total - pix_cnt;

        run.start_index   = 24'(pix_cnt);
        run.start_address = cfg_flip ? 24'((h - 1 - pix_cnt / w) * w + pix_cnt % w)
                                     : 24'(pix_cnt);
        run.run_length    = 8'(len);
        run.red           = r;
        run.green         = g;
        run.blue          = bl;
        run.alpha         = a;
        pix_cnt += len;
        run.image_done    = (pix_cnt >= total);
        runs_pending.push_back(run);
    endfunction

    task automatic send_item(input logic rt, input logic [7:0] idx, input logic [23:0] colour,
                             input logic [7:0] b);
        int unsigned gap, pick;
        gap = 0;
        if (gaps_on) begin
            pick = $urandom_range(0, 99);
            if (pick >= 93)      gap = $urandom_range(8, 40);
            else if (pick >= 65) gap = $urandom_range(1, 3);
        end
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_req_type       <= rt;
        s_palette_index  <= idx;
        s_palette_colour <= colour;
        s_data_byte      <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (rt == REQ_PALETTE) pal_mem[idx] = colour;
        else decode_data_byte(b);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(REQ_DATA, 8'($urandom), 24'($urandom), b);
    endtask

    // Complete the pixel in progress, or send a whole one
    task automatic send_pixel();
        int unsigned n;
        n = pixel_bytes() > byte_idx ? pixel_bytes() - byte_idx : 1;
        repeat (n) send_byte(rand_byte());
    endtask

    // Drain the block before touching its registers
    task automatic settle();
        @(negedge aclk) s_valid <= 1'b0;
        while (runs_pending.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input int unsigned v);
        settle();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= DIM_W'(v);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_IMAGE_WIDTH:     cfg_w = DIM_W'(v);
            REG_IMAGE_HEIGHT:    cfg_h = DIM_W'(v);
            REG_RLE_MODE:        cfg_rle = v[0];
            REG_BYTES_PER_PIXEL: cfg_bpp = v[2:0];
            REG_PALETTED:        cfg_pal = v[0];
            REG_FLIP_ROWS:       cfg_flip = v[0];
            default: ;
        endcase
    endtask

    task automatic set_frame(input int unsigned w, input int unsigned h);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
    endtask

    // Resize the frame so that at least the given number of pixels remain
    task automatic open_frame(input int unsigned w, input int unsigned margin);
        int unsigned h;
        if (w * FRAME_MAX <= pix_cnt + margin) w = (pix_cnt + margin) / FRAME_MAX + 1;
        h = (pix_cnt + margin + w - 1) / w;
        set_frame(w, h);
    endtask

    task automatic test_reset_state();
        send_byte(8'h11);
        send_byte(8'h22);
        send_byte(8'h33);
        send_byte(8'h44);
        // single-pixel frame is now full: drop this one
        send_byte(8'hff);
    endtask

    task automatic test_palette_lookup();
        write_reg(REG_PALETTED, 1);
        write_reg(REG_BYTES_PER_PIXEL, BPP_1);
        write_reg(REG_FLIP_ROWS, 1);
        set_frame(1, FRAME_MAX);
        send_item(REQ_PALETTE, 8'h00, 24'h00ff00, 8'h00);
        send_item(REQ_PALETTE, 8'h01, 24'hffffff, 8'h00);
        send_item(REQ_PALETTE, 8'hff, 24'h5a3cc3, 8'h00);
        send_byte(8'h00);
        send_byte(8'h01);
        send_byte(8'hff);
        // overwrite then read the same entry
        send_item(REQ_PALETTE, 8'h01, 24'h123456, 8'h00);
        send_byte(8'h01);
    endtask

    task automatic test_pixel_formats();
        write_reg(REG_PALETTED, 0);
        set_frame(5, FRAME_MAX);
        send_byte(8'h00);
        send_byte(8'hff);
        write_reg(REG_BYTES_PER_PIXEL, BPP_2);
        send_byte(8'hff);
        send_byte(8'hff);
        send_byte(8'h1f);
        send_byte(8'h83);
        send_byte(8'he0);
        send_byte(8'h7c);
        write_reg(REG_BYTES_PER_PIXEL, BPP_3);
        send_byte(8'h01);
        send_byte(8'h02);
        send_byte(8'h03);
        write_reg(REG_BYTES_PER_PIXEL, BPP_4);
        send_byte(8'haa);
        send_byte(8'hbb);
        send_byte(8'hcc);
        send_byte(8'h00);
    endtask

    task automatic test_rle_packets();
        write_reg(REG_RLE_MODE, 1);
        write_reg(REG_BYTES_PER_PIXEL, BPP_1);
        write_reg(REG_FLIP_ROWS, 0);
        send_byte(8'hff);
        send_byte(8'h40);
        send_byte(8'h01);
        send_byte(8'h10);
        send_byte(8'h20);
        send_byte(8'h80);
        send_byte(8'h30);
    endtask

    task automatic test_mid_pixel_config();
        write_reg(REG_RLE_MODE, 0);
        write_reg(REG_BYTES_PER_PIXEL, BPP_4);
        send_byte(8'ha5);
        write_reg(REG_BYTES_PER_PIXEL, BPP_2);
        send_byte(8'h5a);
        write_reg(REG_BYTES_PER_PIXEL, BPP_3);
        send_byte(8'h11);
        send_byte(8'h22);
        // header arrives with a partial pixel pending: drop the partial
        write_reg(REG_RLE_MODE, 1);
        send_byte(8'h00);
        write_reg(REG_BYTES_PER_PIXEL, BPP_1);
        send_byte(8'h77);
    endtask

    task automatic test_run_clamp();
        open_frame(1, 3);
        send_byte(8'hff);
        send_byte(8'h9c);
        send_byte(8'h01);
        open_frame(1, 2);
        send_byte(8'h04);
        repeat (5) send_byte(rand_byte());
        // shrink below the pixel count: frame counts as complete
        set_frame(1, 1);
        send_byte(8'h42);
    endtask

    task automatic test_random_stream();
        int unsigned ph, pick, count, stop_at, idx;
        gaps_on = 1'b1;
        for (idx = 0; idx < 256; idx++) begin
            send_item(REQ_PALETTE, 8'(idx), 24'($urandom), 8'($urandom));
        end
        for (ph = 0; ph < 12; ph++) begin
            write_reg(REG_RLE_MODE, $urandom_range(0, 1));
            write_reg(REG_BYTES_PER_PIXEL, $urandom_range(1, 4));
            write_reg(REG_PALETTED, $urandom_range(0, 1));
            write_reg(REG_FLIP_ROWS, $urandom_range(0, 1));
            if (ph == 0) set_frame(FRAME_MAX, FRAME_MAX);
            else if ($urandom_range(0, 3) == 0)
                open_frame($urandom_range(1, 64), $urandom_range(1, 60));
            else if ($urandom_range(0, 1) == 0)
                open_frame($urandom_range(1, 64), $urandom_range(500, 60000));
            else
                open_frame($urandom_range(1, FRAME_MAX), $urandom_range(500, 60000));
            gaps_on = ($urandom_range(0, 3) != 0);
            stop_at = items_sent + 110;
            while (items_sent < stop_at && pix_cnt < frame_total()) begin
                pick = $urandom_range(0, 99);
                if (pick < 4) begin
                    send_item(REQ_PALETTE, 8'($urandom), 24'($urandom), 8'($urandom));
                end else if (pick < 12) begin
                    repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
                end else if (cfg_rle && pkt_left == 0) begin
                    count = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 127)
                                                         : $urandom_range(0, 7);
                    send_byte({1'($urandom_range(0, 1)), 7'(count)});
                end else begin
                    send_pixel();
                end
            end
            send_byte(8'($urandom));
        end
    endtask

    initial begin : result_backpressure
        int unsigned on_len, off_len;
        forever begin
            on_len  = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200)
                                                  : $urandom_range(1, 8);
            off_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(1, 3);
            repeat (on_len) @(negedge aclk) m_ready <= 1'b1;
            repeat (off_len) @(negedge aclk) m_ready <= 1'b0;
        end
    end

    always @(posedge aclk) begin : run_check
        out_t got;
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            got.start_index   = m_start_index;
            got.start_address = m_start_address;
            got.run_length    = m_run_length;
            got.red           = m_red;
            got.green         = m_green;
            got.blue          = m_blue;
            got.alpha         = m_alpha;
            got.image_done    = m_image_done;
            if (runs_pending.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS) $display("unexpected run: %s", run_text(got));
            end else begin
                want = runs_pending.pop_front();
                if (got !== want) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("run mismatch at %0t", $realtime);
                        $display("  expected %s", run_text(want));
                        $display("  actual   %s", run_text(got));
                    end
                end
            end
        end
    end

    initial begin
        #30_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;
        test_reset_state();
        test_palette_lookup();
        test_pixel_formats();
        test_rle_packets();
        test_mid_pixel_config();
        test_run_clamp();
        test_random_stream();
        @(negedge aclk) s_valid <= 1'b0;
        while (runs_pending.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> tga_pixel_stream_decoder.f
src/tgapd_pkg.sv
src/tgapd_palette_ram.sv
src/tgapd_cfg.sv
src/tgapd_raster.sv
src/tga_pixel_stream_decoder.sv
tb/tga_pixel_stream_decoder_test.sv
